@@ design/quicksort_comparison_counter_assert.svh @@
// Assertion macros shared by the quicksort comparison counter checker
`ifndef QUICKSORT_COMPARISON_COUNTER_ASSERT_SVH
`define QUICKSORT_COMPARISON_COUNTER_ASSERT_SVH

// same-cycle implication, held off during reset
`define QCC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define QCC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/qcc_pkg.sv @@
// Package: sizes, sequencer states and shared types of the quicksort comparison counter
package qcc_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int STACK_DEPTH = 8;

    localparam int VAL_W  = 32;
    localparam int CNT_W  = 11;
    localparam int IDX_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int STK_AW = $clog2(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_LOAD,
        S_RANGE,
        S_P_RD,
        S_P_W1,
        S_P_W2,
        S_SC_RD,
        S_SC_CMP,
        S_SC_WR,
        S_F_RD,
        S_F_W1,
        S_F_W2,
        S_SPLIT,
        S_EMIT_RD,
        S_EMIT_LD
    } qcc_state_t;

    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } qcc_range_t;

    typedef struct packed {
        logic                    push;
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic [CNT_W-1:0]        count;
        logic                    ovf;
    } qcc_emit_t;

endpackage

@@ design/qcc_engine.sv @@
// Sort engine: element store, range stack and the partition sequencer
module qcc_engine import qcc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [VAL_W-1:0] in_value,
    input  logic                    in_last,
    input  logic                    out_free,
    output qcc_emit_t               emit
);

    qcc_state_t state_reg, state_next;

    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic [IDX_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  bnd_reg, bnd_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic signed [VAL_W-1:0] pivot_reg, pivot_next;
    logic signed [VAL_W-1:0] tmp_reg, tmp_next;

    qcc_range_t stack_reg [STACK_DEPTH];
    logic       push_en;
    qcc_range_t push_range;

    logic signed [VAL_W-1:0] mem [MAX_ITEMS];
    logic signed [VAL_W-1:0] rd_a_reg, rd_b_reg;
    logic                    we, re;
    logic [ADDR_W-1:0]       waddr, raddr_a, raddr_b;
    logic signed [VAL_W-1:0] wdata;

    logic              accept, has_room;
    logic [IDX_W-1:0]  size, size_m1, hi_m1, bnd_m1, j_inc, cnt_inc;
    logic [IDX_W-1:0]  lsize, rsize, bsize_m1;
    logic              less, j_more, final_k;
    qcc_range_t        small_r, big_r, pop_r;
    logic [SP_W-1:0]   sp_dec;

    assign accept   = in_valid && in_ready;
    assign has_room = cnt_reg < IDX_W'(MAX_ITEMS);
    assign cnt_inc  = cnt_reg + 1'b1;
    assign size     = hi_reg - lo_reg;
    assign size_m1  = size - 1'b1;
    assign hi_m1    = hi_reg - 1'b1;
    assign bnd_m1   = bnd_reg - 1'b1;
    assign j_inc    = j_reg + 1'b1;
    assign j_more   = j_inc < hi_reg;
    assign less     = rd_a_reg < pivot_reg;
    assign final_k  = (IDX_W'(k_reg) + 1'b1) == cnt_reg;
    assign sp_dec   = sp_reg - 1'b1;
    assign pop_r    = stack_reg[sp_dec[STK_AW-1:0]];

    // pivot lands at bnd-1: left [lo, bnd-1), right [bnd, hi)
    assign lsize = bnd_m1 - lo_reg;
    assign rsize = hi_reg - bnd_reg;

    always_comb begin
        if (lsize <= rsize) begin
            small_r = '{lo: lo_reg, hi: bnd_m1};
            big_r   = '{lo: bnd_reg, hi: hi_reg};
        end else begin
            small_r = '{lo: bnd_reg, hi: hi_reg};
            big_r   = '{lo: lo_reg, hi: bnd_m1};
        end
        bsize_m1 = big_r.hi - big_r.lo - 1'b1;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD: begin
                if (accept && in_last) begin
                    state_next = S_RANGE;
                end
            end
            S_RANGE: begin
                if (size >= IDX_W'(2)) begin
                    state_next = S_P_RD;
                end else if (sp_reg == '0) begin
                    state_next = S_EMIT_RD;
                end
            end
            S_P_RD:   state_next = S_P_W1;
            S_P_W1:   state_next = S_P_W2;
            S_P_W2:   state_next = S_SC_RD;
            S_SC_RD:  state_next = S_SC_CMP;
            S_SC_CMP: begin
                if (less) begin
                    state_next = S_SC_WR;
                end else if (j_more) begin
                    state_next = S_SC_RD;
                end else begin
                    state_next = S_F_RD;
                end
            end
            S_SC_WR:  state_next = j_more ? S_SC_RD : S_F_RD;
            S_F_RD:   state_next = S_F_W1;
            S_F_W1:   state_next = S_F_W2;
            S_F_W2:   state_next = S_SPLIT;
            S_SPLIT:  state_next = S_RANGE;
            S_EMIT_RD: state_next = S_EMIT_LD;
            S_EMIT_LD: begin
                if (out_free) begin
                    state_next = final_k ? S_LOAD : S_EMIT_RD;
                end
            end
            default:  state_next = S_LOAD;
        endcase
    end

    // outputs: handshake, store port controls, result request
    always_comb begin
        in_ready = 1'b0;
        we       = 1'b0;
        waddr    = '0;
        wdata    = tmp_reg;
        re       = 1'b0;
        raddr_a  = lo_reg[ADDR_W-1:0];
        raddr_b  = bnd_m1[ADDR_W-1:0];
        emit     = '0;
        emit.value = rd_a_reg;
        case (state_reg)
            S_LOAD: begin
                in_ready = 1'b1;
                we       = accept && has_room;
                waddr    = cnt_reg[ADDR_W-1:0];
                wdata    = in_value;
            end
            S_P_RD: begin
                re      = 1'b1;
                raddr_b = hi_m1[ADDR_W-1:0];
            end
            S_P_W1, S_F_W1: begin
                we    = 1'b1;
                waddr = lo_reg[ADDR_W-1:0];
                wdata = rd_b_reg;
            end
            S_P_W2: begin
                we    = 1'b1;
                waddr = hi_m1[ADDR_W-1:0];
            end
            S_SC_RD: begin
                re      = 1'b1;
                raddr_a = j_reg[ADDR_W-1:0];
                raddr_b = bnd_reg[ADDR_W-1:0];
            end
            S_SC_CMP: begin
                we    = less;
                waddr = j_reg[ADDR_W-1:0];
                wdata = rd_b_reg;
            end
            S_SC_WR: begin
                we    = 1'b1;
                waddr = bnd_reg[ADDR_W-1:0];
            end
            S_F_RD: begin
                re = 1'b1;
            end
            S_F_W2: begin
                we    = 1'b1;
                waddr = bnd_m1[ADDR_W-1:0];
            end
            S_EMIT_RD: begin
                re      = 1'b1;
                raddr_a = k_reg;
            end
            S_EMIT_LD: begin
                emit.push  = out_free;
                emit.last  = final_k;
                emit.count = final_k ? total_reg : '0;
                emit.ovf   = final_k && ovf_reg;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        total_next = total_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        j_next     = j_reg;
        bnd_next   = bnd_reg;
        sp_next    = sp_reg;
        k_next     = k_reg;
        pivot_next = pivot_reg;
        tmp_next   = tmp_reg;
        push_en    = 1'b0;
        push_range = big_r;
        case (state_reg)
            S_LOAD: begin
                if (accept) begin
                    if (has_room) begin
                        cnt_next = cnt_inc;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (in_last) begin
                        lo_next = '0;
                        hi_next = has_room ? cnt_inc : cnt_reg;
                        sp_next = '0;
                        k_next  = '0;
                    end
                end
            end
            S_RANGE: begin
                if (size != '0) begin
                    total_next = total_reg + CNT_W'(size_m1);
                end
                if (size < IDX_W'(2) && sp_reg != '0) begin
                    sp_next = sp_dec;
                    lo_next = pop_r.lo;
                    hi_next = pop_r.hi;
                end
            end
            S_P_W1: begin
                pivot_next = rd_b_reg;
                tmp_next   = rd_a_reg;
            end
            S_P_W2: begin
                j_next   = lo_reg + 1'b1;
                bnd_next = lo_reg + 1'b1;
            end
            S_SC_CMP: begin
                if (less) begin
                    tmp_next = rd_a_reg;
                end else begin
                    j_next = j_inc;
                end
            end
            S_SC_WR: begin
                bnd_next = bnd_reg + 1'b1;
                j_next   = j_inc;
            end
            S_F_W1: begin
                tmp_next = rd_a_reg;
            end
            S_SPLIT: begin
                lo_next = small_r.lo;
                hi_next = small_r.hi;
                if (big_r.hi != big_r.lo) begin
                    if (sp_reg < SP_W'(STACK_DEPTH)) begin
                        push_en = 1'b1;
                        sp_next = sp_reg + 1'b1;
                    end else begin
                        // no room: range left as is, still counted
                        total_next = total_reg + CNT_W'(bsize_m1);
                    end
                end
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    if (final_k) begin
                        cnt_next   = '0;
                        total_next = '0;
                        ovf_next   = 1'b0;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default: begin
                push_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            total_reg <= '0;
            sp_reg    <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            j_reg     <= '0;
            bnd_reg   <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            total_reg <= total_next;
            sp_reg    <= sp_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            j_reg     <= j_next;
            bnd_reg   <= bnd_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        pivot_reg <= pivot_next;
        tmp_reg   <= tmp_next;
        if (push_en) begin
            stack_reg[sp_reg[STK_AW-1:0]] <= push_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_a_reg <= mem[raddr_a];
            rd_b_reg <= mem[raddr_b];
        end
    end

endmodule

@@ design/quicksort_comparison_counter.sv @@
// Top level: quicksort with comparison count, request channels and result register
//
// Input channel s_*: one signed 32-bit element per request, s_last_in closes the set.
// Elements are taken one per cycle while loading; up to 64 are kept, any more are
// dropped and flagged. The request carrying s_last_in starts the sort and s_ready
// stays low until the sorted set has been handed over.
// Result channel m_*: the set in ascending order, one element per request, with
// m_last_out on the final one. m_compare_count and m_overflow are meaningful on that
// final element and read zero on the others.
// The sort runs on one store with two read ports and one write port under a single
// sequencer: each partition moves the pivot to the front, scans the range swapping
// smaller elements down, places the pivot and stacks the larger side.
// Each result is then read from the store and loaded into the result register.
// A stalled receiver holds the result register; the sequencer waits on it. After
// the last result is loaded into the register the block takes the next set at once.
// Reset (aresetn low, synchronous) empties the set, count, flag and result register.
module quicksort_comparison_counter import qcc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [VAL_W-1:0] s_value_in,
    input  logic                    s_last_in,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_value_out,
    output logic                    m_last_out,
    output logic [CNT_W-1:0]        m_compare_count,
    output logic                    m_overflow
);

    qcc_emit_t emit;
    logic      out_free;

    logic                    m_valid_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic                    last_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    ovf_reg;

    assign out_free = !m_valid_reg || m_ready;

    qcc_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_value (s_value_in),
        .in_last  (s_last_in),
        .out_free (out_free),
        .emit     (emit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.push) begin
            value_reg <= emit.value;
            last_reg  <= emit.last;
            count_reg <= emit.count;
            ovf_reg   <= emit.ovf;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_value_out     = value_reg;
    assign m_last_out      = last_reg;
    assign m_compare_count = count_reg;
    assign m_overflow      = ovf_reg;

endmodule

@@ design/quicksort_comparison_counter_checker.sv @@
// Port-level checker for the quicksort comparison counter, bound to the top level
`include "quicksort_comparison_counter_assert.svh"

module quicksort_comparison_counter_checker import qcc_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic signed [VAL_W-1:0] s_value_in,
    input logic                    s_last_in,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [VAL_W-1:0] m_value_out,
    input logic                    m_last_out,
    input logic [CNT_W-1:0]        m_compare_count,
    input logic                    m_overflow
);

    // stalled result holds
    `QCC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_value_out) && $stable(m_last_out), "stalled result changed")

    // count and flag only on the closing result
    `QCC_ASSERT_NOW(a_tail_only, aclk, aresetn, m_valid && !m_last_out, m_compare_count == '0 && !m_overflow, "count or flag on a non-final result")

    // closing element starts the sort, input is held off
    `QCC_ASSERT_NEXT(a_sort_blocks, aclk, aresetn, s_valid && s_ready && s_last_in, !s_ready, "input taken while sorting")

    // non-final result waiting: set still being emitted, no input
    `QCC_ASSERT_NOW(a_emit_blocks, aclk, aresetn, m_valid && !m_last_out, !s_ready, "input taken mid-set")

endmodule

bind quicksort_comparison_counter quicksort_comparison_counter_checker u_checker (.*);
